[rtl/assert_macros.svh]
// Assertion macros shared by the divider RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIDIV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sidiv_pkg.sv]
// Types and constants for the signed integer divider.
// No dependencies; used by every module of the divider.
package sidiv_pkg;

    localparam int DIV_W = 32;
    localparam int CNT_W = $clog2(DIV_W);

    typedef struct packed {
        logic signed [DIV_W-1:0] dividend;
        logic signed [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic signed [DIV_W-1:0] quotient_out;
        logic signed [DIV_W-1:0] remainder_out;
        logic                    zero_divisor;
    } t_div_res;

    // Operands of the shared subtractor: minuend - subtrahend, both unsigned.
    typedef struct packed {
        logic [DIV_W:0] minuend;
        logic [DIV_W:0] subtrahend;
    } t_sub_in;

    typedef struct packed {
        logic [DIV_W-1:0] diff;
        logic             borrow;
    } t_sub_out;

    // Sequencer status toward the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_status;

endpackage

[rtl/sidiv_sub.sv]
// Shared subtractor of the divider: trial subtract, magnitude and negation.
// Depends on sidiv_pkg.
module sidiv_sub (
    input  sidiv_pkg::t_sub_in  i_sub,
    output sidiv_pkg::t_sub_out o_sub
);
    import sidiv_pkg::*;

    logic [DIV_W+1:0] w_full;

    assign w_full       = {1'b0, i_sub.minuend} - {1'b0, i_sub.subtrahend};
    assign o_sub.diff   = w_full[DIV_W-1:0];
    assign o_sub.borrow = w_full[DIV_W+1];

endmodule

[rtl/sidiv_seq.sv]
// Sequencer and working registers of the divider: magnitudes, restoring
// division one bit per cycle, sign fix-up. Depends on sidiv_pkg, sidiv_sub.
module sidiv_seq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  sidiv_pkg::t_div_req    i_req,
    input  logic                   i_res_take,
    output sidiv_pkg::t_seq_status o_status,
    output sidiv_pkg::t_div_res    o_res
);
    import sidiv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS_A,
        S_ABS_B,
        S_DIV,
        S_NEG_Q,
        S_NEG_R,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_q;      // dividend magnitude, then quotient
    logic [DIV_W-1:0] r_p;      // partial remainder
    logic [DIV_W-1:0] r_d;      // divisor, then its magnitude
    logic             r_sa;
    logic             r_sb;
    logic             r_zero;

    t_sub_in  w_sub_in;
    t_sub_out w_sub_out;
    logic     w_accept;

    sidiv_sub u_sub (
        .i_sub (w_sub_in),
        .o_sub (w_sub_out)
    );

    assign w_accept = i_req_valid && (r_state == S_IDLE);

    always_comb begin
        w_sub_in = '0;
        case (r_state)
            S_ABS_A: w_sub_in.subtrahend = {1'b0, r_q};
            S_ABS_B: w_sub_in.subtrahend = {1'b0, r_d};
            S_DIV: begin
                w_sub_in.minuend    = {r_p, r_q[DIV_W-1]};
                w_sub_in.subtrahend = {1'b0, r_d};
            end
            S_NEG_Q: w_sub_in.subtrahend = {1'b0, r_q};
            S_NEG_R: w_sub_in.subtrahend = {1'b0, r_p};
            default: w_sub_in = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_d    <= i_req.divisor;
                        r_sa   <= i_req.dividend[DIV_W-1];
                        r_sb   <= i_req.divisor[DIV_W-1];
                        r_zero <= (i_req.divisor == '0);
                        if (i_req.divisor == '0) begin
                            // report all ones for both results
                            r_q     <= '1;
                            r_p     <= '1;
                            r_state <= S_DONE;
                        end else begin
                            r_q     <= i_req.dividend;
                            r_p     <= '0;
                            r_state <= S_ABS_A;
                        end
                    end
                end
                S_ABS_A: begin
                    if (r_sa) begin
                        r_q <= w_sub_out.diff;
                    end
                    r_state <= S_ABS_B;
                end
                S_ABS_B: begin
                    if (r_sb) begin
                        r_d <= w_sub_out.diff;
                    end
                    r_cnt   <= CNT_W'(DIV_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // keep the difference only when it did not go negative
                    if (w_sub_out.borrow) begin
                        r_p <= w_sub_in.minuend[DIV_W-1:0];
                    end else begin
                        r_p <= w_sub_out.diff;
                    end
                    r_q <= {r_q[DIV_W-2:0], !w_sub_out.borrow};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_NEG_Q;
                    end
                end
                S_NEG_Q: begin
                    if (r_sa ^ r_sb) begin
                        r_q <= w_sub_out.diff;
                    end
                    r_state <= S_NEG_R;
                end
                S_NEG_R: begin
                    if (r_sa) begin
                        r_p <= w_sub_out.diff;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status.busy     = (r_state != S_IDLE);
    assign o_status.done     = (r_state == S_DONE);
    assign o_res.quotient_out  = r_q;
    assign o_res.remainder_out = r_p;
    assign o_res.zero_divisor  = r_zero;

endmodule

[rtl/signed_integer_divider_core.sv]
// Signed 32-bit truncating divider: quotient and remainder, zero-divisor flag.
// Each request runs magnitude, quotient-bit and sign fix-up steps on the one shared subtractor,
// then a hand-over and an idle step; a zero divisor goes straight to the hand-over. A new
// request is taken only once the previous one has been handed over and the sequencer is idle.
// Reset (synchronous, active low) empties the sequencer and the result register.
// Depends on sidiv_pkg, sidiv_seq, sidiv_sub and assert_macros.svh.
module signed_integer_divider_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  sidiv_pkg::t_div_req i_req,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output sidiv_pkg::t_div_res o_res
);
    import sidiv_pkg::*;

`include "assert_macros.svh"

    t_seq_status w_status;
    t_div_res    w_seq_res;
    logic        w_take;

    logic        r_out_valid;
    t_div_res    r_out;

    // Sequencer owns the working registers and drives the shared subtractor.
    sidiv_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .i_res_take  (w_take),
        .o_status    (w_status),
        .o_res       (w_seq_res)
    );

    // Take a request only while the sequencer is empty.
    assign o_req_ready = !w_status.busy;

    // Hand a finished result to the output register when it is empty or
    // draining this cycle; the sequencer then frees up for the next request
    // even while that result waits downstream.
    assign w_take = w_status.done && (!r_out_valid || i_res_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_out       <= w_seq_res;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // A zero divisor must always report all ones in both results.
    `SIDIV_ASSERT_IMPLY(a_zero_div_ones, i_clk, i_rst_n, r_out_valid && r_out.zero_divisor, r_out.quotient_out == '1 && r_out.remainder_out == '1, "zero divisor result not all ones")

    // An accepted request keeps the sequencer busy in the next cycle.
    `SIDIV_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready, "ready after accepting a request")

    // A handed-over result shows up at the output in the next cycle.
    `SIDIV_ASSERT_NEXT(a_take_lands, i_clk, i_rst_n, w_take, r_out_valid, "finished result lost")

endmodule
